@@ rtl/core/css_pkg.sv @@
// css_pkg: shared types and constants of the comment and string styler
// covers the transaction payloads, the configuration register set and the lexer state
// no dependencies
`default_nettype none

package css_pkg;

	localparam int MAX_MARK_LEN = 4;
	// markers hold at most four bytes in a register
	localparam int MARK_CAP     = (MAX_MARK_LEN < 4) ? MAX_MARK_LEN : 4;
	localparam int PEND_DEPTH   = MAX_MARK_LEN - 1;
	localparam int PEND_W       = (MAX_MARK_LEN > 1) ? $clog2(MAX_MARK_LEN) : 1;
	localparam int CNT_W        = $clog2(MAX_MARK_LEN + 1);
	localparam int MREM_W       = (MARK_CAP > 1) ? $clog2(MARK_CAP) : 1;
	localparam int MARK_W       = 35;
	localparam int CFG_IDX_W    = 3;

	typedef enum logic [2:0] {
		ST_DEFAULT   = 3'd0,
		ST_LINE      = 3'd1,
		ST_DOC_LINE  = 3'd2,
		ST_STRING    = 3'd3,
		ST_BLOCK     = 3'd4,
		ST_DOC_BLOCK = 3'd5
	} style_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LINE_MARK      = 3'd0,
		CFG_DOC_LINE_MARK  = 3'd1,
		CFG_BLOCK_MARK     = 3'd2,
		CFG_DOC_BLOCK_MARK = 3'd3,
		CFG_BLOCK_END_MARK = 3'd4,
		CFG_STRING_MARK    = 3'd5,
		CFG_STRINGS_EN     = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [2:0]  len;
		logic [31:0] bytes;
	} mark_t;

	typedef struct packed {
		mark_t line_mark;
		mark_t doc_line_mark;
		mark_t block_mark;
		mark_t doc_block_mark;
		mark_t block_end_mark;
		mark_t string_mark;
		logic  strings_enabled;
	} cfg_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       line_end;
	} in_t;

	typedef struct packed {
		logic [2:0] style_code;
		logic       is_terminator;
		logic       last_of_run;
	} out_t;

	typedef logic [MAX_MARK_LEN-1:0][7:0] win_t;

	typedef struct packed {
		style_t            mode;
		logic [MREM_W-1:0] mrem;
		logic              closes;
		logic [15:0]       prior;
		logic [1:0]        cil;
	} lex_state_t;

endpackage

`default_nettype wire

@@ rtl/core/css_cfg.sv @@
// css_cfg: configuration register file of the styler
// write-only register set, always ready; depends on css_pkg
`default_nettype none

module css_cfg import css_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [MARK_W-1:0]    cfg_data,
	output cfg_t                 cfg
);

	localparam logic [MARK_W-1:0] RST_LINE      = 35'h2_0000_2323;
	localparam logic [MARK_W-1:0] RST_DOC_LINE  = 35'h3_0021_2323;
	localparam logic [MARK_W-1:0] RST_BLOCK     = 35'h2_0000_2A23;
	localparam logic [MARK_W-1:0] RST_DOC_BLOCK = 35'h3_0021_2A23;
	localparam logic [MARK_W-1:0] RST_BLOCK_END = 35'h2_0000_232A;
	localparam logic [MARK_W-1:0] RST_STRING    = 35'h1_0000_0022;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.line_mark       <= RST_LINE;
			cfg_q.doc_line_mark   <= RST_DOC_LINE;
			cfg_q.block_mark      <= RST_BLOCK;
			cfg_q.doc_block_mark  <= RST_DOC_BLOCK;
			cfg_q.block_end_mark  <= RST_BLOCK_END;
			cfg_q.string_mark     <= RST_STRING;
			cfg_q.strings_enabled <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_LINE_MARK:      cfg_q.line_mark       <= cfg_data;
				CFG_DOC_LINE_MARK:  cfg_q.doc_line_mark   <= cfg_data;
				CFG_BLOCK_MARK:     cfg_q.block_mark      <= cfg_data;
				CFG_DOC_BLOCK_MARK: cfg_q.doc_block_mark  <= cfg_data;
				CFG_BLOCK_END_MARK: cfg_q.block_end_mark  <= cfg_data;
				CFG_STRING_MARK:    cfg_q.string_mark     <= cfg_data;
				CFG_STRINGS_EN:     cfg_q.strings_enabled <= cfg_data[0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/css_lex.sv @@
// css_lex: combinational style decision for one character position
// matches markers over the look-ahead window and computes the next lexer state
// depends on css_pkg
`default_nettype none

module css_lex import css_pkg::*; (
	input  cfg_t             cfg,
	input  lex_state_t       cur,
	input  win_t             win,
	input  logic [CNT_W-1:0] n,
	input  logic             terminate,
	output style_t           style,
	output lex_state_t       nxt
);

	function automatic logic [2:0] mlen(mark_t m);
		return (m.len > 3'(MARK_CAP)) ? 3'(MARK_CAP) : m.len;
	endfunction

	function automatic logic hit(mark_t m, win_t w, logic [CNT_W-1:0] cnt);
		logic [2:0] l;
		logic       ok;
		l  = mlen(m);
		ok = (l != 3'd0) && (int'(l) <= int'(cnt));
		for (int i = 0; i < MARK_CAP; i++) begin
			if (i < int'(l) && w[i] != m.bytes[8*i +: 8])
				ok = 1'b0;
		end
		return ok;
	endfunction

	logic [2:0] end_len;
	logic [2:0] str_len;
	logic [2:0] open_len;
	logic       escaped;
	logic       opening;
	style_t     fb_mode;
	style_t     open_st;

	assign end_len = mlen(cfg.block_end_mark);
	assign str_len = mlen(cfg.string_mark);

	// backslash before the quote escapes it, a doubled backslash does not
	assign escaped = (cur.cil != 2'd0) && (cur.prior[7:0] == 8'h5C) &&
		!((cur.cil == 2'd2) && (cur.prior[15:8] == 8'h5C));

	// a style whose closing marker was emptied drops back to default
	always_comb begin
		fb_mode = cur.mode;
		if ((cur.mode inside {ST_BLOCK, ST_DOC_BLOCK}) && end_len == 3'd0)
			fb_mode = ST_DEFAULT;
		if (cur.mode == ST_STRING && str_len == 3'd0)
			fb_mode = ST_DEFAULT;
	end

	always_comb begin
		nxt      = cur;
		style    = cur.mode;
		opening  = 1'b0;
		open_st  = ST_DEFAULT;
		open_len = 3'd0;
		nxt.prior = {cur.prior[7:0], win[0]};
		nxt.cil   = (cur.cil == 2'd2) ? cur.cil : cur.cil + 2'd1;

		if (terminate) begin
			style      = fb_mode;
			nxt.mode   = (fb_mode inside {ST_LINE, ST_DOC_LINE}) ? ST_DEFAULT : fb_mode;
			nxt.mrem   = '0;
			nxt.closes = 1'b0;
			nxt.prior  = '0;
			nxt.cil    = '0;
		end else if (cur.mrem != '0) begin
			// rest of a matched marker keeps the style without new checks
			style    = cur.mode;
			nxt.mrem = MREM_W'(cur.mrem - 1'b1);
			if (cur.mrem == MREM_W'(1) && cur.closes) begin
				nxt.mode   = ST_DEFAULT;
				nxt.closes = 1'b0;
			end
		end else begin
			nxt.mode = fb_mode;
			case (fb_mode)
				ST_LINE, ST_DOC_LINE: begin
					style = fb_mode;
				end
				ST_STRING: begin
					style = ST_STRING;
					if (hit(cfg.string_mark, win, n) && !escaped)
						nxt.mode = ST_DEFAULT;
				end
				ST_BLOCK, ST_DOC_BLOCK: begin
					style = fb_mode;
					if (hit(cfg.block_end_mark, win, n)) begin
						nxt.mrem = MREM_W'(end_len - 3'd1);
						if (end_len > 3'd1)
							nxt.closes = 1'b1;
						else
							nxt.mode = ST_DEFAULT;
					end
				end
				default: begin
					if (hit(cfg.doc_line_mark, win, n)) begin
						style    = ST_DOC_LINE;
						nxt.mode = ST_DOC_LINE;
					end else if (hit(cfg.line_mark, win, n)) begin
						style    = ST_LINE;
						nxt.mode = ST_LINE;
					end else if (cfg.strings_enabled && hit(cfg.string_mark, win, n)) begin
						opening  = 1'b1;
						open_st  = ST_STRING;
						open_len = str_len;
					end else if (hit(cfg.doc_block_mark, win, n)) begin
						opening  = 1'b1;
						open_st  = ST_DOC_BLOCK;
						open_len = mlen(cfg.doc_block_mark);
					end else if (hit(cfg.block_mark, win, n)) begin
						opening  = 1'b1;
						open_st  = ST_BLOCK;
						open_len = mlen(cfg.block_mark);
					end else begin
						style    = ST_DEFAULT;
						nxt.mode = ST_DEFAULT;
					end
				end
			endcase

			if (opening) begin
				style      = open_st;
				nxt.mode   = open_st;
				nxt.mrem   = MREM_W'(open_len - 3'd1);
				nxt.closes = 1'b0;
				// without an end marker a block covers only its own opener
				if (open_st != ST_STRING && end_len == 3'd0) begin
					if (open_len > 3'd1)
						nxt.closes = 1'b1;
					else
						nxt.mode = ST_DEFAULT;
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/comment_string_styler.sv @@
// comment_string_styler: tags each source character with a comment or string style
//
// Input channel (in_valid/in_stall/in_data): one transaction per character, or an
// end-of-line transaction with line_end set. A character transaction gives no result
// until three characters are pending, then one result for the oldest pending one.
// An end-of-line transaction gives one result per pending character followed by
// the terminator result; last_of_run marks the final result of each transaction.
// Output channel (out_valid/out_stall/out_data): registered results.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready;
// the user must write it only while the block is idle; the block does not enforce it.
// Each result passes through the input register, then the result register.
// Character transactions are taken one per cycle while the output does not stall;
// an end-of-line transaction holds the input register until each pending character
// and the terminator have their results, as the lexer produces one result per cycle.
// Reset empties the pending window, returns to default style and loads the default
// markers. A stall on the output holds the result register; the input stalls while
// its held transaction needs a result that the held result register cannot take,
// and while an end-of-line transaction is still flushing.
// Depends on css_pkg, css_cfg and css_lex.
`default_nettype none

module comment_string_styler import css_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_t                  in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_t                 out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [MARK_W-1:0]    cfg_data
);

	cfg_t              cfg;
	logic              valid_s1;
	in_t               item_s1;
	logic [7:0]        pend_q [PEND_DEPTH];
	logic [PEND_W-1:0] pcount_q;
	lex_state_t        lex_q;
	lex_state_t        lex_nxt;
	logic              out_valid_q;
	out_t              out_q;

	win_t              win;
	logic [CNT_W-1:0]  win_n;
	logic              terminate;
	logic              need_out;
	logic              done;
	logic              out_free;
	logic              advance;
	logic              consume;
	logic              emit;
	logic              full;
	style_t            style;

	css_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	css_lex u_lex (
		.cfg       (cfg),
		.cur       (lex_q),
		.win       (win),
		.n         (win_n),
		.terminate (terminate),
		.style     (style),
		.nxt       (lex_nxt)
	);

	assign full = (pcount_q == PEND_W'(PEND_DEPTH));

	always_comb begin
		win       = '0;
		win_n     = '0;
		terminate = 1'b0;
		need_out  = 1'b0;
		done      = 1'b1;
		for (int i = 0; i < PEND_DEPTH; i++)
			win[i] = pend_q[i];
		if (item_s1.line_end) begin
			need_out = 1'b1;
			win_n    = CNT_W'(pcount_q);
			if (pcount_q == '0)
				terminate = 1'b1;
			else
				done = 1'b0;
		end else if (full) begin
			need_out            = 1'b1;
			win[MAX_MARK_LEN-1] = item_s1.char_code;
			win_n               = CNT_W'(MAX_MARK_LEN);
		end
	end

	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && (!need_out || out_free);
	assign consume  = advance && done;
	assign emit     = advance && need_out;
	assign in_stall = valid_s1 && !consume;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			pcount_q    <= '0;
			lex_q       <= '{mode: ST_DEFAULT, default: '0};
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				valid_s1 <= 1'b1;
			else if (consume)
				valid_s1 <= 1'b0;

			if (emit)
				lex_q <= lex_nxt;

			if (advance) begin
				if (!item_s1.line_end && !full)
					pcount_q <= PEND_W'(pcount_q + 1'b1);
				else if (item_s1.line_end && pcount_q != '0)
					pcount_q <= PEND_W'(pcount_q - 1'b1);
			end

			if (emit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			item_s1 <= in_data;

		if (advance) begin
			if (!item_s1.line_end && !full) begin
				pend_q[pcount_q] <= item_s1.char_code;
			end else if (need_out && !terminate) begin
				// window slides by one; a flushed tail slot is never read again
				for (int i = 0; i < PEND_DEPTH - 1; i++)
					pend_q[i] <= pend_q[i+1];
				pend_q[PEND_DEPTH-1] <= item_s1.char_code;
			end
		end

		if (emit) begin
			out_q.style_code    <= style;
			out_q.is_terminator <= terminate;
			out_q.last_of_run   <= done;
		end
	end

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pcount_q <= PEND_W'(PEND_DEPTH))
		else $error("pending count beyond window depth");

	a_closes_needs_marker: assert property (@(posedge clk) disable iff (!arst_n)
		lex_q.closes |-> (lex_q.mrem != '0))
		else $error("closing flag set with no marker characters left");

	a_term_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.is_terminator) |-> out_q.last_of_run)
		else $error("terminator result not marked last of run");

	a_line_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(consume && item_s1.line_end) |=>
			(lex_q.cil == 2'd0 && lex_q.prior == 16'd0 && lex_q.mrem == '0 && pcount_q == '0))
		else $error("line history not cleared after line end");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty input register");

endmodule

`default_nettype wire
